[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/nfsf_pkg.sv]
// ----------------------------------------------------------------------------
// nfsf_pkg
// Types, constants and helpers shared by the next FFT size finder modules.
// ----------------------------------------------------------------------------
package nfsf_pkg;

	localparam int SIZE_BITS_DEF = 24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST_Q,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef logic [1:0] radix_idx_t;

	localparam radix_idx_t RADIX_POW2 = 2'd0;
	localparam radix_idx_t RADIX_LAST = 2'd3;

	typedef struct packed {
		logic load;
		logic init_v;
		logic shift_v;
		logic take_best;
		logic mul_q;
		logic next_radix;
	} cmd_t;

	typedef struct packed {
		logic q_le_n;
		logic v_lt_n;
		logic pow2_pass;
		logic last_radix;
	} stat_t;

	// Odd radix used for each pass; the first pass is the pure power of two.
	function automatic logic [2:0] odd_radix(input radix_idx_t idx);
		logic [2:0] p;
		unique case (idx)
			2'd0:    p = 3'd1;
			2'd1:    p = 3'd3;
			2'd2:    p = 3'd5;
			default: p = 3'd7;
		endcase
		return p;
	endfunction

endpackage

[sv/nfsf_ctrl.sv]
// ----------------------------------------------------------------------------
// nfsf_ctrl
// Sequencer that walks the odd parts and the doublings of the search.
// ----------------------------------------------------------------------------
module nfsf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  nfsf_pkg::stat_t stat,
	output nfsf_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);
	import nfsf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_TEST_Q;
				end
			end
			ST_TEST_Q: begin
				if (stat.q_le_n) begin
					state_d = ST_SHIFT;
				end else if (stat.last_radix) begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				if (!stat.v_lt_n) begin
					state_d = ST_TEST_Q;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_TEST_Q: begin
				cmd.init_v     = stat.q_le_n;
				cmd.next_radix = !stat.q_le_n && !stat.last_radix;
			end
			ST_SHIFT: begin
				cmd.shift_v    = stat.v_lt_n;
				cmd.take_best  = !stat.v_lt_n;
				cmd.next_radix = !stat.v_lt_n && stat.pow2_pass;
				cmd.mul_q      = !stat.v_lt_n && !stat.pow2_pass;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

[sv/nfsf_dp.sv]
// ----------------------------------------------------------------------------
// nfsf_dp
// Datapath holding the request, the odd part, the doubling candidate and
// the best size found so far.
// ----------------------------------------------------------------------------
module nfsf_dp #(
	parameter int SIZE_BITS = nfsf_pkg::SIZE_BITS_DEF
) (
	input  logic                 clk,
	input  nfsf_pkg::cmd_t        cmd,
	input  logic [SIZE_BITS-1:0] requested_size,
	output nfsf_pkg::stat_t       stat,
	output logic [SIZE_BITS:0]   fft_size
);
	import nfsf_pkg::*;

	localparam int QW = SIZE_BITS + 3;
	localparam int VW = SIZE_BITS + 1;

	logic [SIZE_BITS-1:0] n_q;
	logic [QW-1:0]        q_q;
	logic [VW-1:0]        v_q;
	logic [VW-1:0]        best_q;
	radix_idx_t           r_q;
	radix_idx_t           r_next;
	logic [QW-1:0]        q_low;
	logic [QW-1:0]        q_mul;

	assign r_next = r_q + radix_idx_t'(1);
	assign q_low  = QW'(q_q[SIZE_BITS-1:0]);

	always_comb begin
		unique case (odd_radix(r_q))
			3'd3:    q_mul = (q_low << 1) + q_low;
			3'd5:    q_mul = (q_low << 2) + q_low;
			3'd7:    q_mul = (q_low << 3) - q_low;
			default: q_mul = q_low;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= (requested_size == '0) ? SIZE_BITS'(1) : requested_size;
			q_q    <= QW'(1);
			r_q    <= RADIX_POW2;
			best_q <= '1;
		end else begin
			if (cmd.init_v) begin
				v_q <= {q_q[SIZE_BITS-1:0], 1'b0};
			end
			if (cmd.shift_v) begin
				v_q <= {v_q[VW-2:0], 1'b0};
			end
			if (cmd.take_best && (v_q < best_q)) begin
				best_q <= v_q;
			end
			if (cmd.mul_q) begin
				q_q <= q_mul;
			end
			if (cmd.next_radix) begin
				r_q <= r_next;
				q_q <= QW'(odd_radix(r_next));
			end
		end
	end

	assign stat.q_le_n     = q_q <= QW'(n_q);
	assign stat.v_lt_n     = v_q < VW'(n_q);
	assign stat.pow2_pass  = r_q == RADIX_POW2;
	assign stat.last_radix = r_q == RADIX_LAST;
	assign fft_size        = best_q;

endmodule

[sv/next_fft_size_finder_core.sv]
// ----------------------------------------------------------------------------
// next_fft_size_finder_core
// Finds the smallest even transform length, at least the request, of the
// form 2^a * p^b with p one of 3, 5 or 7.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low;
// a request of zero is treated as one. Busy then stays high while the search
// runs and no new request is taken.
// The search visits the pure power of two and every odd part 3^b, 5^b and
// 7^b not above the request, and for each one doubles a candidate once per
// cycle until it reaches the request. One shifter and comparator do all the
// doubling.
// The result appears on fft_size for exactly one cycle with done high and
// must be taken in that cycle, since the receiver cannot stall the block.
// Busy falls in the cycle after done, so requests are handled one at a time.
// Reset clears the sequencer to idle; no result is pending after reset.
// ----------------------------------------------------------------------------
module next_fft_size_finder_core #(
	parameter int SIZE_BITS = nfsf_pkg::SIZE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [SIZE_BITS-1:0] requested_size,
	output logic                 done,
	output logic [SIZE_BITS:0]   fft_size
);
	import nfsf_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	nfsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	nfsf_dp #(
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.requested_size (requested_size),
		.stat           (stat),
		.fft_size       (fft_size)
	);

endmodule

[sv/nfsf_checker.sv]
// ----------------------------------------------------------------------------
// nfsf_props
// Port-level checks of the request and result sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfsf_props #(
	parameter int SIZE_BITS = nfsf_pkg::SIZE_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic [SIZE_BITS-1:0] requested_size,
	input logic                 done,
	input logic [SIZE_BITS:0]   fft_size
);

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done, "busy not raised after request")
	`ASSERT_SAME(a_done_busy, clk, arst_n, done, busy, "result shown while idle")
	`ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy && !done, "block not idle after result")
	`ASSERT_SAME(a_size_even, clk, arst_n, done, !fft_size[0] && (fft_size != '0), "result not even")
	`ASSERT_SAME(a_size_range, clk, arst_n, done, fft_size <= {1'b1, {SIZE_BITS{1'b0}}}, "result too large")

endmodule

bind next_fft_size_finder_core nfsf_props #(.SIZE_BITS(SIZE_BITS)) u_nfsf_props (.*);
